// ----- hw/rtl/csol_pkg.sv -----
// Shared constants and codes of the column span occlusion list.
package csol_pkg;

  localparam int MAX_POSTS_DEF   = 64;
  localparam int MAX_COLUMNS_DEF = 1024;
  localparam int MAX_RESULTS     = 64;
  localparam int COL_W           = 10;
  localparam int VW_W            = 11;
  localparam logic [VW_W-1:0] VIEW_WIDTH_RST = VW_W'(320);

  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_SOLID = 2'd1;
  localparam logic [1:0] KIND_PASS  = 2'd2;
  localparam logic [1:0] KIND_QUERY = 2'd3;

endpackage

// ----- hw/rtl/csol_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module csol_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/column_span_occlusion_list_top.sv -----
// An item holds in_stall while it reads posts, while it moves entries on insert or collapse,
// and through its clip, tail, write-back and final-beat steps.
// One item at a time: in_stall stays high until its final beat is registered.
// A clear rewrites the sentinel posts in S_CLR0 and S_CLR1. out_stall can hold fragment and final beats.
// Reset (rst, synchronous) loads view_width 320 and writes the sentinel posts into the
// list RAM in S_CLR0 and S_CLR1, with in_stall high.
module column_span_occlusion_list_top #(
  parameter int MAX_POSTS   = csol_pkg::MAX_POSTS_DEF,
  parameter int MAX_COLUMNS = csol_pkg::MAX_COLUMNS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [csol_pkg::VW_W-1:0] cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               kind,
  input  logic [csol_pkg::COL_W-1:0] first_col,
  input  logic [csol_pkg::COL_W-1:0] last_col,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [csol_pkg::COL_W-1:0] frag_first,
  output logic [csol_pkg::COL_W-1:0] frag_last,
  output logic                     visible,
  output logic                     covered,
  output logic                     overflow,
  output logic                     final_result
);

  import csol_pkg::*;

  localparam int UW   = ($clog2(MAX_COLUMNS + 1) > COL_W) ? $clog2(MAX_COLUMNS + 1) : COL_W;
  localparam int CW   = UW + 1;
  localparam int EW   = CW + 1;
  localparam int IW   = $clog2(MAX_POSTS);
  localparam int NW   = $clog2(MAX_POSTS + 1);
  localparam int RW   = $clog2(MAX_RESULTS);
  localparam logic [RW-1:0] RES_CAP = RW'(MAX_RESULTS - 1);
  localparam logic signed [CW-1:0] LOW_START = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] HIGH_END  = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] MINUS_ONE = {CW{1'b1}};
  localparam logic [NW-1:0] POSTS_FULL = NW'(MAX_POSTS);
  localparam logic [UW:0]   COLS_MAX   = (UW+1)'(MAX_COLUMNS);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_CLR0    = 4'd1;
  localparam logic [3:0] S_CLR1    = 4'd2;
  localparam logic [3:0] S_FIND_RD = 4'd3;
  localparam logic [3:0] S_FIND_CK = 4'd4;
  localparam logic [3:0] S_CLIP    = 4'd5;
  localparam logic [3:0] S_LOOP_RD = 4'd6;
  localparam logic [3:0] S_LOOP_CK = 4'd7;
  localparam logic [3:0] S_TAIL    = 4'd8;
  localparam logic [3:0] S_WB      = 4'd9;
  localparam logic [3:0] S_COL_RD  = 4'd10;
  localparam logic [3:0] S_COL_WR  = 4'd11;
  localparam logic [3:0] S_INS_RD  = 4'd12;
  localparam logic [3:0] S_INS_WR  = 4'd13;
  localparam logic [3:0] S_INS_S   = 4'd14;
  localparam logic [3:0] S_FIN     = 4'd15;

  logic [3:0]            state;
  logic                  boot;
  logic [VW_W-1:0]       view_width;
  logic [1:0]            op;
  logic                  solid;
  logic signed [EW-1:0]  f;
  logic signed [EW-1:0]  l;
  logic [NW-1:0]         count;
  logic [IW-1:0]         s;
  logic [IW-1:0]         n;
  logic [NW-1:0]         k;
  logic signed [CW-1:0]  ss;
  logic signed [CW-1:0]  se;
  logic signed [CW-1:0]  ne;
  logic                  cov;
  logic                  ovf;
  logic [RW-1:0]         ecnt;
  logic                  pend_v;
  logic [COL_W-1:0]      pend_a;
  logic [COL_W-1:0]      pend_b;

  logic                  we;
  logic [IW-1:0]         waddr;
  logic [2*CW-1:0]       wdata;
  logic [IW-1:0]         raddr;
  logic [2*CW-1:0]       rdata;

  logic signed [EW-1:0]  rs;
  logic signed [EW-1:0]  re;
  logic signed [EW-1:0]  sse;
  logic signed [EW-1:0]  see;
  logic signed [EW-1:0]  nee;
  logic signed [EW-1:0]  key;
  logic signed [CW-1:0]  vw_clamp;
  logic [IW-1:0]         gone;
  logic                  can_send;
  logic                  emit_req;
  logic signed [EW-1:0]  emit_a;
  logic signed [EW-1:0]  emit_b;
  logic                  emit_take;
  logic                  out_load;
  logic                  go;
  logic                  s_more;
  logic                  n_more;

  csol_ram #(
    .WIDTH (2*CW),
    .DEPTH (MAX_POSTS)
  ) u_posts (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rs   = {rdata[2*CW-1], rdata[2*CW-1:CW]};
  assign re   = {rdata[CW-1], rdata[CW-1:0]};
  assign sse  = {ss[CW-1], ss};
  assign see  = {se[CW-1], se};
  assign nee  = {ne[CW-1], ne};
  assign key  = (op == KIND_QUERY) ? l : (f - EW'(1));
  assign gone = n - s;

  assign s_more = ((NW'(s) + NW'(1)) < count);
  assign n_more = ((NW'(n) + NW'(1)) < count);

  always_comb begin
    if (view_width == '0) begin
      vw_clamp = CW'(1);
    end else if ({{(UW+1-VW_W){1'b0}}, view_width} > COLS_MAX) begin
      vw_clamp = CW'(MAX_COLUMNS);
    end else begin
      vw_clamp = {{(CW-VW_W){1'b0}}, view_width};
    end
  end

  // Read address is held per state so the registered data stays valid while waiting.
  always_comb begin
    unique case (state)
      S_LOOP_RD, S_LOOP_CK: raddr = n + IW'(1);
      S_INS_RD, S_INS_WR, S_COL_RD, S_COL_WR: raddr = k[IW-1:0];
      default: raddr = s;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = s;
    wdata = {ss, se};
    unique case (state)
      S_CLR0: begin
        we    = 1'b1;
        waddr = '0;
        wdata = {LOW_START, MINUS_ONE};
      end
      S_CLR1: begin
        we    = 1'b1;
        waddr = IW'(1);
        wdata = {vw_clamp, HIGH_END};
      end
      S_WB: begin
        we = 1'b1;
      end
      S_COL_WR: begin
        we    = 1'b1;
        waddr = k[IW-1:0] - gone;
        wdata = rdata;
      end
      S_INS_WR: begin
        we    = 1'b1;
        waddr = k[IW-1:0] + IW'(1);
        wdata = rdata;
      end
      S_INS_S: begin
        we    = 1'b1;
        wdata = {f[CW-1:0], l[CW-1:0]};
      end
      default: ;
    endcase
  end

  always_comb begin
    emit_req = 1'b0;
    emit_a   = f;
    emit_b   = l;
    unique case (state)
      S_CLIP: begin
        if (f < sse) begin
          emit_req = 1'b1;
          if (!(l < sse - EW'(1))) begin
            emit_b = sse - EW'(1);
          end
        end
      end
      S_LOOP_CK: begin
        if (l >= rs - EW'(1)) begin
          emit_req = 1'b1;
          emit_a   = nee + EW'(1);
          emit_b   = rs - EW'(1);
        end
      end
      S_TAIL: begin
        emit_req = 1'b1;
        emit_a   = nee + EW'(1);
      end
      default: ;
    endcase
  end

  assign can_send  = !out_valid || !out_stall;
  assign go        = !emit_req || (ecnt >= RES_CAP) || !pend_v || can_send;
  assign emit_take = emit_req && go && (ecnt < RES_CAP);
  assign out_load  = (emit_take && pend_v) || ((state == S_FIN) && can_send);
  assign in_stall  = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR0;
      boot       <= 1'b1;
      view_width <= VIEW_WIDTH_RST;
      count      <= NW'(2);
      out_valid  <= 1'b0;
      pend_v     <= 1'b0;
    end else begin
      if (cfg_we) begin
        view_width <= cfg_wdata;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      // Hold the newest fragment back until it is known whether it is the last one.
      if (emit_take) begin
        if (pend_v) begin
          frag_first   <= pend_a;
          frag_last    <= pend_b;
          visible      <= 1'b1;
          covered      <= 1'b0;
          overflow     <= 1'b0;
          final_result <= 1'b0;
        end
        pend_v <= 1'b1;
        pend_a <= emit_a[COL_W-1:0];
        pend_b <= emit_b[COL_W-1:0];
        ecnt   <= ecnt + RW'(1);
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op     <= kind;
            solid  <= (kind == KIND_SOLID);
            f      <= {{(EW-COL_W){1'b0}}, first_col};
            l      <= {{(EW-COL_W){1'b0}}, last_col};
            cov    <= 1'b0;
            ovf    <= 1'b0;
            ecnt   <= '0;
            pend_v <= 1'b0;
            s      <= '0;
            unique case (kind)
              KIND_CLEAR: state <= S_CLR0;
              KIND_QUERY: begin
                if (last_col < first_col) begin
                  cov   <= 1'b1;
                  state <= S_FIN;
                end else begin
                  state <= S_FIND_RD;
                end
              end
              default: state <= (last_col < first_col) ? S_FIN : S_FIND_RD;
            endcase
          end
        end
        S_CLR0: state <= S_CLR1;
        S_CLR1: begin
          count <= NW'(2);
          boot  <= 1'b0;
          state <= boot ? S_IDLE : S_FIN;
        end
        S_FIND_RD: state <= S_FIND_CK;
        S_FIND_CK: begin
          if (s_more && (re < key)) begin
            s     <= s + IW'(1);
            state <= S_FIND_RD;
          end else if (op == KIND_QUERY) begin
            cov   <= (f >= rs) && (l <= re);
            state <= S_FIN;
          end else begin
            ss    <= rdata[2*CW-1:CW];
            se    <= rdata[CW-1:0];
            n     <= s;
            state <= S_CLIP;
          end
        end
        S_CLIP: begin
          if (go) begin
            ne <= se;
            if ((f < sse) && (l < sse - EW'(1))) begin
              if (!solid) begin
                state <= S_FIN;
              end else if (count >= POSTS_FULL) begin
                ovf   <= 1'b1;
                state <= S_FIN;
              end else begin
                k     <= count - NW'(1);
                state <= S_INS_RD;
              end
            end else begin
              if (solid && (f < sse)) begin
                ss <= f[CW-1:0];
              end
              if (l <= see) begin
                state <= solid ? S_WB : S_FIN;
              end else begin
                state <= S_LOOP_RD;
              end
            end
          end
        end
        S_LOOP_RD: state <= n_more ? S_LOOP_CK : S_TAIL;
        S_LOOP_CK: begin
          if (!emit_req) begin
            state <= S_TAIL;
          end else if (go) begin
            n  <= n + IW'(1);
            ne <= rdata[CW-1:0];
            if (l <= re) begin
              if (solid) begin
                se <= rdata[CW-1:0];
              end
              state <= solid ? S_WB : S_FIN;
            end else begin
              state <= S_LOOP_RD;
            end
          end
        end
        S_TAIL: begin
          if (go) begin
            if (solid) begin
              se <= l[CW-1:0];
            end
            state <= solid ? S_WB : S_FIN;
          end
        end
        S_WB: begin
          k     <= NW'(n) + NW'(1);
          state <= (n == s) ? S_FIN : S_COL_RD;
        end
        S_COL_RD: begin
          if (k < count) begin
            state <= S_COL_WR;
          end else begin
            count <= count - NW'(gone);
            state <= S_FIN;
          end
        end
        S_COL_WR: begin
          k     <= k + NW'(1);
          state <= S_COL_RD;
        end
        S_INS_RD: state <= S_INS_WR;
        S_INS_WR: begin
          if (k[IW-1:0] == s) begin
            state <= S_INS_S;
          end else begin
            k     <= k - NW'(1);
            state <= S_INS_RD;
          end
        end
        S_INS_S: begin
          count <= count + NW'(1);
          state <= S_FIN;
        end
        S_FIN: begin
          if (can_send) begin
            frag_first   <= pend_v ? pend_a : '0;
            frag_last    <= pend_v ? pend_b : '0;
            visible      <= pend_v;
            covered      <= cov;
            overflow     <= ovf;
            final_result <= 1'b1;
            pend_v       <= 1'b0;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
